// ===== hdl/nntt_pkg.sv =====
// Shared types, constants and codes of the nearest-neighbor track table.
package nntt_pkg;

    localparam int MAX_ENTRIES = 32;
    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    // Operand and product widths of the shared multiplier.
    localparam int MUL_W = 26;
    localparam int PROD_W = 2 * MUL_W;

    // Configuration register indexes.
    localparam logic [1:0] CFG_RADIUS_LIMIT = 2'd0;
    localparam logic [1:0] CFG_TABLE_LIMIT = 2'd1;
    localparam logic [1:0] CFG_BLEND_GAIN = 2'd2;
    localparam logic [1:0] CFG_MERGE_RANGE = 2'd3;

    localparam logic [16:0] GAIN_ONE = 17'd65536;
    localparam logic [15:0] HITS_MAX = 16'hFFFF;

    // Result kinds carried on the master-side tuser.
    typedef enum logic [1:0] {
        OUT_NEW = 2'd0,
        OUT_MERGED = 2'd1,
        OUT_READ_OK = 2'd2,
        OUT_READ_BEYOND = 2'd3
    } outcome_t;

    // One table entry as stored in the entry memory.
    typedef struct packed {
        logic [23:0] x;
        logic [23:0] y;
        logic [15:0] radius;
        logic [15:0] hits;
    } entry_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RD_WAIT,
        S_RD_DATA,
        S_PREP,
        S_PREP2,
        S_SC_WAIT,
        S_SC_DX,
        S_SC_DY,
        S_SC_CMP,
        S_MG_WAIT,
        S_MG_X,
        S_MG_Y,
        S_MG_R,
        S_MG_W,
        S_APPEND,
        S_EV_WAIT,
        S_EV_CMP,
        S_SH_WAIT,
        S_SH_WR,
        S_EMIT
    } state_t;

endpackage

// ===== hdl/nntt_mul.sv =====
// Shared signed multiplier with a registered product.
module nntt_mul
    import nntt_pkg::*;
(
    input  logic                     clk,
    input  logic signed [MUL_W-1:0]  op_a,
    input  logic signed [MUL_W-1:0]  op_b,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] prod_reg;

    // Product register; it needs no reset.
    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

// ===== hdl/nearest_neighbor_track_table_top.sv =====
// Top level of the nearest-neighbor track table with its sequencer and entry memory.
// A read request waits for its memory read and then takes the entry, or goes straight
// to the result when the index lies beyond the count. An observe request first squares
// the merge range and then scans every entry: each waits for its memory read, goes
// through the one shared multiplier twice and then through a compare. A merge blends x,
// y and radius of the nearest entry on the multiplier and writes it back. An append
// writes the new entry at the end; when it evicts, a search for the lowest hit count
// and a shift of each entry after the victim down into the gap come first. A last
// step hands the result to the output register, and that step repeats for as long
// as an earlier result still waits there untaken. The output register holds the
// result until it is taken while the next transaction is already accepted.
module nearest_neighbor_track_table_top
    import nntt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Slave side. tdata: pos_x[23:0], pos_y[47:24], obs_radius[63:48], read_index[68:64].
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,
    // tuser: req_type[0].
    input  logic [0:0]  s_tuser,
    // Master side. tdata: slot[4:0], evicted[5], out_x[29:6], out_y[53:30],
    // out_radius[69:54], out_hits[85:70], used_count[91:86].
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,
    // tuser: outcome[1:0].
    output logic [1:0]  m_tuser,
    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data
);

    // Configuration registers.
    logic [15:0] radius_limit_reg;
    logic [5:0]  table_limit_reg;
    logic [16:0] blend_gain_reg;
    logic [15:0] merge_range_reg;

    // Control state.
    state_t         state_reg, state_next;
    logic [CNT_W-1:0] total_reg, total_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic           found_reg, found_next;
    logic           ev_reg, ev_next;
    logic           m_tvalid_reg, m_tvalid_next;

    // Working payload.
    logic [23:0]      px_reg, px_next;
    logic [23:0]      py_reg, py_next;
    logic [15:0]      rad_reg, rad_next;
    logic [IDX_W-1:0] best_reg, best_next;
    logic [IDX_W-1:0] victim_reg, victim_next;
    logic [15:0]      min_reg, min_next;
    logic [48:0]      sq_reg, sq_next;
    logic [49:0]      best_d2_reg, best_d2_next;
    logic [IDX_W-1:0] addr_reg, addr_next;
    entry_t           ent_reg, ent_next;
    outcome_t         outcome_reg, outcome_next;
    logic [IDX_W-1:0] slot_reg, slot_next;

    // Output register.
    outcome_t         o_outcome_reg, o_outcome_next;
    logic [IDX_W-1:0] o_slot_reg, o_slot_next;
    logic             o_ev_reg, o_ev_next;
    entry_t           o_ent_reg, o_ent_next;
    logic [CNT_W-1:0] o_used_reg, o_used_next;

    // Entry memory.
    entry_t           mem [MAX_ENTRIES];
    entry_t           rd_data_reg;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;

    // Shared multiplier.
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;

    // Datapath helpers.
    logic [16:0]            gain;
    logic signed [MUL_W-1:0] gain_op;
    logic signed [MUL_W-1:0] dx, dy, dr;
    logic signed [MUL_W-1:0] delta;
    logic [49:0]            d2;
    logic [5:0]             limit;
    logic [15:0]            in_rad;
    logic [15:0]            hits_inc;
    logic                   s_fire;

    nntt_mul u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    // Memory write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[addr_reg];
    end

    // Configuration writes; they must arrive only while the block is idle, which the block itself does not enforce.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_limit_reg <= 16'hFFFF;
            table_limit_reg  <= 6'd32;
            blend_gain_reg   <= 17'd19661;
            merge_range_reg  <= 16'd512;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_RADIUS_LIMIT: radius_limit_reg <= cfg_data[15:0];
                CFG_TABLE_LIMIT:  table_limit_reg  <= cfg_data[5:0];
                CFG_BLEND_GAIN:   blend_gain_reg   <= cfg_data;
                CFG_MERGE_RANGE:  merge_range_reg  <= cfg_data[15:0];
                default:          radius_limit_reg <= radius_limit_reg;
            endcase
        end
    end

    // Differences against the entry being read, and the clamped operands.
    assign gain    = (blend_gain_reg > GAIN_ONE) ? GAIN_ONE : blend_gain_reg;
    assign gain_op = MUL_W'({1'b0, gain});
    assign dx      = MUL_W'($signed({px_reg[23], px_reg}) -
                            $signed({rd_data_reg.x[23], rd_data_reg.x}));
    assign dy      = MUL_W'($signed({py_reg[23], py_reg}) -
                            $signed({rd_data_reg.y[23], rd_data_reg.y}));
    assign dr      = MUL_W'($signed({1'b0, rad_reg}) - $signed({1'b0, rd_data_reg.radius}));
    assign delta   = prod[MUL_W+15:16];
    assign d2      = {1'b0, sq_reg} + {1'b0, prod[48:0]};
    assign in_rad  = s_tdata[63:48];
    assign hits_inc = (rd_data_reg.hits == HITS_MAX) ? HITS_MAX : rd_data_reg.hits + 16'd1;
    assign limit   = (table_limit_reg == 6'd0) ? 6'd1 :
                     (table_limit_reg > 6'(MAX_ENTRIES)) ? 6'(MAX_ENTRIES) : table_limit_reg;
    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;

    // Sequencer: next state, memory port and multiplier operands.
    always_comb
    begin
        state_next     = state_reg;
        total_next     = total_reg;
        cnt_next       = cnt_reg;
        found_next     = found_reg;
        ev_next        = ev_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        rad_next       = rad_reg;
        best_next      = best_reg;
        victim_next    = victim_reg;
        min_next       = min_reg;
        sq_next        = sq_reg;
        best_d2_next   = best_d2_reg;
        addr_next      = addr_reg;
        ent_next       = ent_reg;
        outcome_next   = outcome_reg;
        slot_next      = slot_reg;
        m_tvalid_next  = m_tvalid_reg;
        o_outcome_next = o_outcome_reg;
        o_slot_next    = o_slot_reg;
        o_ev_next      = o_ev_reg;
        o_ent_next     = o_ent_reg;
        o_used_next    = o_used_reg;
        wr_en          = 1'b0;
        wr_addr        = cnt_reg[IDX_W-1:0];
        wr_data        = rd_data_reg;
        mul_a          = '0;
        mul_b          = '0;

        // A waiting result leaves once the master side takes it.
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_fire)
                begin
                    px_next  = s_tdata[23:0];
                    py_next  = s_tdata[47:24];
                    rad_next = (in_rad > radius_limit_reg) ? radius_limit_reg : in_rad;
                    ev_next  = 1'b0;
                    if (s_tuser[0])
                    begin
                        slot_next = s_tdata[68:64];
                        if (CNT_W'(s_tdata[68:64]) < total_reg)
                        begin
                            addr_next  = s_tdata[68:64];
                            state_next = S_RD_WAIT;
                        end
                        else
                        begin
                            ent_next     = '0;
                            outcome_next = OUT_READ_BEYOND;
                            state_next   = S_EMIT;
                        end
                    end
                    else
                    begin
                        state_next = S_PREP;
                    end
                end
            end

            S_RD_WAIT:
            begin
                state_next = S_RD_DATA;
            end

            S_RD_DATA:
            begin
                ent_next     = rd_data_reg;
                outcome_next = OUT_READ_OK;
                state_next   = S_EMIT;
            end

            // Square the merge range on the shared multiplier.
            S_PREP:
            begin
                mul_a      = MUL_W'({1'b0, merge_range_reg});
                mul_b      = MUL_W'({1'b0, merge_range_reg});
                state_next = S_PREP2;
            end

            S_PREP2:
            begin
                best_d2_next = {18'd0, prod[31:0]};
                found_next   = 1'b0;
                cnt_next     = '0;
                addr_next    = '0;
                state_next   = (total_reg == '0) ? S_APPEND : S_SC_WAIT;
            end

            S_SC_WAIT:
            begin
                state_next = S_SC_DX;
            end

            S_SC_DX:
            begin
                mul_a      = dx;
                mul_b      = dx;
                state_next = S_SC_DY;
            end

            S_SC_DY:
            begin
                sq_next    = prod[48:0];
                mul_a      = dy;
                mul_b      = dy;
                state_next = S_SC_CMP;
            end

            // Keep the first strictly nearest entry inside the merge range.
            S_SC_CMP:
            begin
                if (d2 < best_d2_reg)
                begin
                    best_d2_next = d2;
                    best_next    = cnt_reg[IDX_W-1:0];
                    found_next   = 1'b1;
                end
                if (cnt_reg + CNT_W'(1) == total_reg)
                begin
                    if (found_next)
                    begin
                        addr_next  = best_next;
                        state_next = S_MG_WAIT;
                    end
                    else
                    begin
                        state_next = S_APPEND;
                    end
                end
                else
                begin
                    cnt_next   = cnt_reg + CNT_W'(1);
                    addr_next  = cnt_next[IDX_W-1:0];
                    state_next = S_SC_WAIT;
                end
            end

            S_MG_WAIT:
            begin
                state_next = S_MG_X;
            end

            S_MG_X:
            begin
                mul_a      = gain_op;
                mul_b      = dx;
                state_next = S_MG_Y;
            end

            S_MG_Y:
            begin
                ent_next.x = rd_data_reg.x + delta[23:0];
                mul_a      = gain_op;
                mul_b      = dy;
                state_next = S_MG_R;
            end

            S_MG_R:
            begin
                ent_next.y = rd_data_reg.y + delta[23:0];
                mul_a      = gain_op;
                mul_b      = dr;
                state_next = S_MG_W;
            end

            // Write the smoothed entry back.
            S_MG_W:
            begin
                ent_next.radius = rd_data_reg.radius + delta[15:0];
                ent_next.hits   = hits_inc;
                wr_en           = 1'b1;
                wr_addr         = best_reg;
                wr_data         = ent_next;
                outcome_next    = OUT_MERGED;
                slot_next       = best_reg;
                state_next      = S_EMIT;
            end

            // Append, or search for the least-seen entry first.
            S_APPEND:
            begin
                if (!ev_reg && total_reg >= limit)
                begin
                    ev_next    = 1'b1;
                    cnt_next   = '0;
                    addr_next  = '0;
                    state_next = S_EV_WAIT;
                end
                else
                begin
                    ent_next.x      = px_reg;
                    ent_next.y      = py_reg;
                    ent_next.radius = rad_reg;
                    ent_next.hits   = 16'd1;
                    wr_en           = 1'b1;
                    wr_addr         = total_reg[IDX_W-1:0];
                    wr_data         = ent_next;
                    slot_next       = total_reg[IDX_W-1:0];
                    total_next      = total_reg + CNT_W'(1);
                    outcome_next    = OUT_NEW;
                    state_next      = S_EMIT;
                end
            end

            S_EV_WAIT:
            begin
                state_next = S_EV_CMP;
            end

            S_EV_CMP:
            begin
                if (cnt_reg == '0 || rd_data_reg.hits < min_reg)
                begin
                    min_next    = rd_data_reg.hits;
                    victim_next = cnt_reg[IDX_W-1:0];
                end
                if (cnt_reg + CNT_W'(1) == total_reg)
                begin
                    cnt_next = CNT_W'(victim_next);
                    if (CNT_W'(victim_next) + CNT_W'(1) == total_reg)
                    begin
                        total_next = total_reg - CNT_W'(1);
                        state_next = S_APPEND;
                    end
                    else
                    begin
                        addr_next  = victim_next + IDX_W'(1);
                        state_next = S_SH_WAIT;
                    end
                end
                else
                begin
                    cnt_next   = cnt_reg + CNT_W'(1);
                    addr_next  = cnt_next[IDX_W-1:0];
                    state_next = S_EV_WAIT;
                end
            end

            S_SH_WAIT:
            begin
                state_next = S_SH_WR;
            end

            // Move the next entry down into the gap.
            S_SH_WR:
            begin
                wr_en    = 1'b1;
                wr_addr  = cnt_reg[IDX_W-1:0];
                wr_data  = rd_data_reg;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg + CNT_W'(2) == total_reg)
                begin
                    total_next = total_reg - CNT_W'(1);
                    state_next = S_APPEND;
                end
                else
                begin
                    addr_next  = cnt_reg[IDX_W-1:0] + IDX_W'(2);
                    state_next = S_SH_WAIT;
                end
            end

            // Hand the result to the output register when it is free.
            S_EMIT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next  = 1'b1;
                    o_outcome_next = outcome_reg;
                    o_slot_next    = slot_reg;
                    o_ev_next      = ev_reg;
                    o_ent_next     = ent_reg;
                    o_used_next    = total_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            total_reg    <= '0;
            cnt_reg      <= '0;
            found_reg    <= 1'b0;
            ev_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            total_reg    <= total_next;
            cnt_reg      <= cnt_next;
            found_reg    <= found_next;
            ev_reg       <= ev_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        px_reg        <= px_next;
        py_reg        <= py_next;
        rad_reg       <= rad_next;
        best_reg      <= best_next;
        victim_reg    <= victim_next;
        min_reg       <= min_next;
        sq_reg        <= sq_next;
        best_d2_reg   <= best_d2_next;
        addr_reg      <= addr_next;
        ent_reg       <= ent_next;
        outcome_reg   <= outcome_next;
        slot_reg      <= slot_next;
        o_outcome_reg <= o_outcome_next;
        o_slot_reg    <= o_slot_next;
        o_ev_reg      <= o_ev_next;
        o_ent_reg     <= o_ent_next;
        o_used_reg    <= o_used_next;
    end

    // Master-side packing.
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = o_outcome_reg;
    assign m_tdata  = {4'd0, o_used_reg, o_ent_reg.hits, o_ent_reg.radius,
                       o_ent_reg.y, o_ent_reg.x, o_ev_reg, o_slot_reg};

endmodule

// ===== hdl/nntt_checker.sv =====
// Port-level checker of the nearest-neighbor track table and its bind statement.
module nntt_checker
    import nntt_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [71:0] s_tdata,
    input logic [0:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [1:0]  cfg_index,
    input logic [16:0] cfg_data
);

    // A stalled result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // The block is busy in the cycle after it accepts a transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready stayed high after an accepted transaction");

    // A read beyond the count returns an empty entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == OUT_READ_BEYOND |-> m_tdata[85:5] == '0)
        else $error("read beyond count carries entry data");

    // The entry count never exceeds the table depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[91:86] <= 6'(MAX_ENTRIES))
        else $error("used count above table depth");

endmodule

bind nearest_neighbor_track_table_top nntt_checker u_nntt_checker (.*);
